>>> rtl/bchcs_pkg.sv
package bchcs_pkg;

	// Code geometry.
	localparam int CODE_LEN      = 31;
	localparam int DATA_LEN      = 21;
	localparam int PAR_LEN       = 10;
	localparam int TBL_DEPTH     = 1024;
	localparam int TBL_AW        = 10;
	localparam int SAMPLE_W      = 16;
	localparam int MAG_W         = 15;
	localparam int DIST_W        = 20;
	localparam int POS_W         = 5;
	localparam int ERRCNT_W      = 4;
	localparam int DEPTH_W       = 3;
	localparam int POLY_W        = 11;
	localparam int CFG_IDX_W     = 2;
	localparam int DEF_MAX_DEPTH = 6;

	typedef logic [CODE_LEN-1:0] word_t;
	typedef logic [DATA_LEN-1:0] data_t;
	typedef logic [MAG_W-1:0]    mag_t;
	typedef logic [DIST_W-1:0]   dist_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [POLY_W-1:0]   poly_t;
	typedef logic [1:0]          errs_t;

	localparam dist_t DIST_MAX = '1;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_CHASE_DEPTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY    = 2'd1;
	localparam logic [DEPTH_W-1:0]   RST_CHASE_DEPTH = 3'd3;
	localparam poly_t                RST_GEN_POLY    = 11'd1897;

	// Number of bits a syndrome table entry corrects.
	localparam errs_t ERRS_NONE = 2'd0;
	localparam errs_t ERRS_ONE  = 2'd1;
	localparam errs_t ERRS_TWO  = 2'd2;

	typedef struct packed {
		errs_t errs;
		word_t loc;
	} syn_entry_t;

	// Lookup request into the syndrome table.
	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
	} syn_req_t;

	typedef enum logic [2:0] {
		BLD_CLEAR,
		BLD_SINGLE,
		BLD_PAIR_RD,
		BLD_PAIR_WR,
		BLD_DONE
	} bld_state_t;

	typedef enum logic [3:0] {
		DEC_IDLE,
		DEC_SETUP,
		DEC_SYN,
		DEC_LOOK,
		DEC_ENC,
		DEC_DIST,
		DEC_CMP,
		DEC_NEXT,
		DEC_OUT
	} dec_state_t;

	// Position of the highest set bit of the polynomial; zero for a zero polynomial.
	function automatic logic [3:0] poly_deg(input poly_t poly);
		logic [3:0] d;
		d = '0;
		for (int b = 0; b < POLY_W; b++) begin
			if (poly[b]) begin
				d = 4'(b);
			end
		end
		return d;
	endfunction

endpackage

>>> rtl/bchcs_rem_unit.sv
module bchcs_rem_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bchcs_pkg::word_t  word,
	input  bchcs_pkg::poly_t  poly,
	output logic              done,
	output bchcs_pkg::word_t  rem
);
	import bchcs_pkg::*;

	// Eight dividend bits are folded in per cycle, most significant first.
	localparam int BITS_PER_CYCLE = 8;
	localparam int SH_W           = CODE_LEN + 1;
	localparam int STEPS          = SH_W / BITS_PER_CYCLE;
	localparam logic [1:0] LAST_STEP = 2'(STEPS - 1);

	logic [SH_W-1:0] sh_q;
	word_t           word_q;
	poly_t           r_q;
	poly_t           r_nxt;
	logic [1:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [3:0]      deg;
	logic            has;

	// One step of the serial division.
	always_comb begin
		deg   = poly_deg(poly);
		has   = |poly;
		r_nxt = r_q;
		for (int i = 0; i < BITS_PER_CYCLE; i++) begin
			r_nxt = {r_nxt[POLY_W-2:0], sh_q[SH_W-1-i]};
			if (has && r_nxt[deg]) begin
				r_nxt = r_nxt ^ poly;
			end
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Dividend shift register and partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q   <= {1'b0, word};
			word_q <= word;
			r_q    <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << BITS_PER_CYCLE;
			r_q  <= r_nxt;
		end
	end

	// A zero polynomial leaves the word unreduced.
	assign done = done_q;
	assign rem  = has ? {{(CODE_LEN-PAR_LEN){1'b0}}, r_q[PAR_LEN-1:0]} : word_q;

endmodule

>>> rtl/bchcs_syn_table.sv
module bchcs_syn_table (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rebuild,
	input  bchcs_pkg::poly_t       poly,
	input  bchcs_pkg::syn_req_t    req,
	output bchcs_pkg::syn_entry_t  rd_data,
	output logic                   ready
);
	import bchcs_pkg::*;

	localparam pos_t LAST_POS   = POS_W'(CODE_LEN - 1);
	localparam pos_t PENULT_POS = POS_W'(CODE_LEN - 2);

	syn_entry_t        mem_q [TBL_DEPTH];
	syn_entry_t        rd_q;
	bld_state_t        st_q;
	bld_state_t        st_nxt;
	logic [TBL_AW-1:0] clr_q;
	pos_t              a_q;
	pos_t              b_q;
	word_t             ra_q;
	word_t             rb_q;
	word_t             s;
	word_t             r0;
	word_t             ra_nxt;
	logic [3:0]        deg;
	logic              s_fits;
	logic              ra_fits;
	logic              last_pair;
	logic              advance;
	logic              we;
	logic [TBL_AW-1:0] wa;
	syn_entry_t        wd;
	logic              re;
	logic [TBL_AW-1:0] raddr;

	// Clears the bit at the polynomial's degree, if set.
	function automatic word_t reduce(input word_t v, input poly_t p, input logic [3:0] d);
		word_t r;
		r = v;
		if ((|p) && r[d]) begin
			r = r ^ {{(CODE_LEN-POLY_W){1'b0}}, p};
		end
		return r;
	endfunction

	// Remainders of single-bit patterns are stepped like a shift register.
	always_comb begin
		deg       = poly_deg(poly);
		r0        = reduce(word_t'(1), poly, deg);
		ra_nxt    = reduce({ra_q[CODE_LEN-2:0], 1'b0}, poly, deg);
		s         = ra_q ^ rb_q;
		s_fits    = ~|s[CODE_LEN-1:PAR_LEN];
		ra_fits   = ~|ra_q[CODE_LEN-1:PAR_LEN];
		last_pair = (a_q == PENULT_POS) && (b_q == LAST_POS);
	end

	// Build sequencer: clear, single-bit entries, two-bit entries where still empty, then lookups.
	always_comb begin
		st_nxt  = st_q;
		we      = 1'b0;
		wa      = '0;
		wd      = '0;
		re      = 1'b0;
		raddr   = s[TBL_AW-1:0];
		advance = 1'b0;
		case (st_q)
			BLD_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				if (clr_q == '1) begin
					st_nxt = BLD_SINGLE;
				end
			end
			BLD_SINGLE: begin
				we = ra_fits;
				wa = ra_q[TBL_AW-1:0];
				wd = '{errs: ERRS_ONE, loc: word_t'(1) << a_q};
				if (a_q == LAST_POS) begin
					st_nxt = BLD_PAIR_RD;
				end
			end
			BLD_PAIR_RD: begin
				if (s_fits) begin
					re     = 1'b1;
					st_nxt = BLD_PAIR_WR;
				end else begin
					advance = 1'b1;
					if (last_pair) begin
						st_nxt = BLD_DONE;
					end
				end
			end
			BLD_PAIR_WR: begin
				we      = (rd_q.errs == ERRS_NONE);
				wa      = s[TBL_AW-1:0];
				wd      = '{errs: ERRS_TWO, loc: (word_t'(1) << a_q) | (word_t'(1) << b_q)};
				advance = 1'b1;
				st_nxt  = last_pair ? BLD_DONE : BLD_PAIR_RD;
			end
			BLD_DONE: begin
				re    = req.en;
				raddr = req.addr;
			end
			default: begin
				st_nxt = BLD_CLEAR;
			end
		endcase
		if (rebuild) begin
			st_nxt = BLD_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BLD_CLEAR;
		end else begin
			st_q <= st_nxt;
		end
	end

	// Sweep counters and running remainders.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			a_q   <= '0;
			b_q   <= '0;
			ra_q  <= '0;
			rb_q  <= '0;
		end else if (rebuild) begin
			clr_q <= '0;
		end else begin
			case (st_q)
				BLD_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					a_q   <= '0;
					ra_q  <= r0;
				end
				BLD_SINGLE: begin
					if (a_q == LAST_POS) begin
						a_q  <= '0;
						ra_q <= r0;
						b_q  <= POS_W'(1);
						rb_q <= reduce({r0[CODE_LEN-2:0], 1'b0}, poly, deg);
					end else begin
						a_q  <= a_q + 1'b1;
						ra_q <= ra_nxt;
					end
				end
				default: begin
					if (advance) begin
						if (b_q == LAST_POS) begin
							a_q  <= a_q + 1'b1;
							ra_q <= ra_nxt;
							b_q  <= a_q + POS_W'(2);
							rb_q <= reduce({ra_nxt[CODE_LEN-2:0], 1'b0}, poly, deg);
						end else begin
							b_q  <= b_q + 1'b1;
							rb_q <= reduce({rb_q[CODE_LEN-2:0], 1'b0}, poly, deg);
						end
					end
				end
			endcase
		end
	end

	// Table memory with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rd_data = rd_q;
	assign ready   = (st_q == BLD_DONE) && !rebuild;

endmodule

>>> rtl/bchcs_intake.sv
module bchcs_intake #(
	parameter int WEAK_LEN = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 take,
	input  logic signed [bchcs_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 restart,
	output logic                                 block_done,
	output bchcs_pkg::word_t                     hard,
	output bchcs_pkg::pos_t [WEAK_LEN-1:0]       weak_pos,
	input  bchcs_pkg::pos_t                      mag_addr,
	output bchcs_pkg::mag_t                      mag_data
);
	import bchcs_pkg::*;

	localparam pos_t LAST_POS = POS_W'(CODE_LEN - 1);

	mag_t                  mem_q [CODE_LEN];
	mag_t                  rd_q;
	pos_t                  cnt_q;
	pos_t                  idx;
	word_t                 hard_q;
	pos_t                  pos_q [WEAK_LEN];
	mag_t                  wm_q [WEAK_LEN];
	logic [WEAK_LEN-1:0]   lt;
	logic [SAMPLE_W-1:0]   absv;
	mag_t                  mag;

	// Magnitude with the most negative value saturated.
	always_comb begin
		idx  = restart ? '0 : cnt_q;
		absv = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
		mag  = absv[SAMPLE_W-1] ? '1 : absv[MAG_W-1:0];
		for (int j = 0; j < WEAK_LEN; j++) begin
			lt[j] = (POS_W'(j) >= idx) || (mag < wm_q[j]);
		end
	end

	// Position within the block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= (idx == LAST_POS) ? '0 : idx + 1'b1;
		end
	end

	// Hard word, sorted list of least reliable positions and the magnitude store.
	always_ff @(posedge clk) begin
		if (take) begin
			hard_q     <= {hard_q[CODE_LEN-2:0], sample[SAMPLE_W-1]};
			mem_q[idx] <= mag;
			for (int j = 0; j < WEAK_LEN; j++) begin
				if (lt[j]) begin
					if (j > 0 && lt[(j > 0) ? j - 1 : 0]) begin
						pos_q[j] <= pos_q[(j > 0) ? j - 1 : 0];
						wm_q[j]  <= wm_q[(j > 0) ? j - 1 : 0];
					end else begin
						pos_q[j] <= idx;
						wm_q[j]  <= mag;
					end
				end
			end
		end
		rd_q <= mem_q[mag_addr];
	end

	always_comb begin
		for (int j = 0; j < WEAK_LEN; j++) begin
			weak_pos[j] = pos_q[j];
		end
	end

	assign block_done = take && (idx == LAST_POS);
	assign hard       = hard_q;
	assign mag_data   = rd_q;

endmodule

>>> rtl/bch_31_21_chase_soft_decoder.sv
// Chase soft-decision decoder for the BCH(31,21) code. Soft samples enter one per
// beat, first transmitted bit first; block_restart starts a new block and drops a
// partial one. After the 31st sample the decoder takes no input while it works:
// it tries 2^k flip patterns of the k least reliable positions (k = chase_depth,
// capped at MAX_CHASE_DEPTH), using the shared 8-bit-per-cycle polynomial
// remainder unit once for the syndrome and once more to re-encode a trial that
// decodes. A trial that decodes needs a table lookup when its syndrome is not
// zero, and its distance is summed bit by bit over the bits where
// the re-encoded word differs from the hard word; a trial that does not decode
// ends after the syndrome or the lookup. A block therefore takes its 31 samples,
// the trials and the hand-over of the result. The result register holds one
// result while the next block is loaded. After reset and after each write of
// generator_poly the table is rebuilt: cleared, single-bit, then two-bit entries;
// no sample is accepted meanwhile, and configuration writes are always accepted.
module bch_31_21_chase_soft_decoder #(
	parameter int MAX_CHASE_DEPTH = bchcs_pkg::DEF_MAX_DEPTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [bchcs_pkg::SAMPLE_W-1:0]  soft_sample,
	input  logic                                   block_restart,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [bchcs_pkg::DATA_LEN-1:0]         data_word,
	output logic [bchcs_pkg::ERRCNT_W-1:0]         error_count,
	output logic                                   decode_failed,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [bchcs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bchcs_pkg::POLY_W-1:0]           cfg_data
);
	import bchcs_pkg::*;

	localparam int WL = (MAX_CHASE_DEPTH > 0) ? MAX_CHASE_DEPTH : 1;

	// Configuration registers.
	logic [DEPTH_W-1:0]    depth_q;
	poly_t                 poly_q;
	logic                  rebuild;

	// Decode sequencer state.
	dec_state_t            st_q;
	dec_state_t            st_nxt;
	logic [DEPTH_W-1:0]    k_q;
	logic [DEPTH_W-1:0]    kc;
	logic [WL-1:0]         p_q;
	logic [WL-1:0]         last_p;
	word_t                 trial_q;
	word_t                 trial_c;
	logic [DEPTH_W-1:0]    flips_q;
	logic [DEPTH_W-1:0]    flips_c;
	data_t                 data_q;
	errs_t                 errs_q;
	word_t                 diff_q;
	dist_t                 dist_q;
	logic                  pend_q;
	dist_t                 lead_dist_q;
	logic [ERRCNT_W-1:0]   lead_errs_q;
	data_t                 best_data_q;
	logic                  found_q;
	logic [POS_W-1:0]      lo;
	word_t                 corr;

	// Result register.
	logic                  out_valid_q;
	data_t                 out_data_q;
	logic [ERRCNT_W-1:0]   out_errs_q;
	logic                  out_fail_q;

	// Links to the sub-units.
	logic                  take;
	logic                  blk_done;
	word_t                 hard;
	pos_t [WL-1:0]         weak_pos;
	pos_t                  mag_addr;
	mag_t                  mag_data;
	logic                  rem_start;
	word_t                 rem_word;
	logic                  rem_done;
	word_t                 rem_res;
	syn_req_t              req;
	syn_entry_t            syn_rd;
	logic                  tbl_ready;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == DEC_IDLE) && tbl_ready;
	assign take      = in_valid && in_ready;
	assign rebuild   = cfg_valid && (cfg_index == REG_GEN_POLY);

	bchcs_intake #(
		.WEAK_LEN (WL)
	) u_intake (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.sample     (soft_sample),
		.restart    (block_restart),
		.block_done (blk_done),
		.hard       (hard),
		.weak_pos   (weak_pos),
		.mag_addr   (mag_addr),
		.mag_data   (mag_data)
	);

	bchcs_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.word   (rem_word),
		.poly   (poly_q),
		.done   (rem_done),
		.rem    (rem_res)
	);

	bchcs_syn_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rebuild (rebuild),
		.poly    (poly_q),
		.req     (req),
		.rd_data (syn_rd),
		.ready   (tbl_ready)
	);

	// Trial word, flip count, last pattern and lowest differing bit.
	always_comb begin
		kc      = (depth_q > DEPTH_W'(MAX_CHASE_DEPTH)) ? DEPTH_W'(MAX_CHASE_DEPTH) : depth_q;
		trial_c = hard;
		flips_c = '0;
		for (int j = 0; j < WL; j++) begin
			last_p[j] = (DEPTH_W'(j) < k_q);
			if ((DEPTH_W'(j) < k_q) && p_q[j]) begin
				trial_c = trial_c ^ (word_t'(1) << (POS_W'(CODE_LEN - 1) - weak_pos[j]));
				flips_c = flips_c + 1'b1;
			end
		end
		lo = '0;
		for (int b = CODE_LEN - 1; b >= 0; b--) begin
			if (diff_q[b]) begin
				lo = POS_W'(b);
			end
		end
		mag_addr = POS_W'(CODE_LEN - 1) - lo;
		corr     = trial_q ^ syn_rd.loc;
	end

	// Next state and unit controls.
	always_comb begin
		st_nxt    = st_q;
		rem_start = 1'b0;
		rem_word  = trial_c;
		req       = '0;
		case (st_q)
			DEC_IDLE: begin
				if (blk_done) begin
					st_nxt = DEC_SETUP;
				end
			end
			DEC_SETUP: begin
				rem_start = 1'b1;
				st_nxt    = DEC_SYN;
			end
			DEC_SYN: begin
				if (rem_done) begin
					if (rem_res == '0) begin
						rem_start = 1'b1;
						rem_word  = {trial_q[CODE_LEN-1:PAR_LEN], {PAR_LEN{1'b0}}};
						st_nxt    = DEC_ENC;
					end else if (~|rem_res[CODE_LEN-1:PAR_LEN]) begin
						req.en   = 1'b1;
						req.addr = rem_res[TBL_AW-1:0];
						st_nxt   = DEC_LOOK;
					end else begin
						st_nxt = DEC_NEXT;
					end
				end
			end
			DEC_LOOK: begin
				if (syn_rd.errs != ERRS_NONE) begin
					rem_start = 1'b1;
					rem_word  = {corr[CODE_LEN-1:PAR_LEN], {PAR_LEN{1'b0}}};
					st_nxt    = DEC_ENC;
				end else begin
					st_nxt = DEC_NEXT;
				end
			end
			DEC_ENC: begin
				if (rem_done) begin
					st_nxt = DEC_DIST;
				end
			end
			DEC_DIST: begin
				if ((diff_q == '0) && !pend_q) begin
					st_nxt = DEC_CMP;
				end
			end
			DEC_CMP: begin
				st_nxt = DEC_NEXT;
			end
			DEC_NEXT: begin
				st_nxt = (p_q == last_p) ? DEC_OUT : DEC_SETUP;
			end
			DEC_OUT: begin
				if (!out_valid_q || out_ready) begin
					st_nxt = DEC_IDLE;
				end
			end
			default: begin
				st_nxt = DEC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DEC_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= RST_CHASE_DEPTH;
			poly_q  <= RST_GEN_POLY;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CHASE_DEPTH: depth_q <= cfg_data[DEPTH_W-1:0];
				REG_GEN_POLY:    poly_q  <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Control flags of the sequencer and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			p_q         <= '0;
			k_q         <= '0;
		end else begin
			if ((st_q == DEC_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				DEC_IDLE: begin
					if (blk_done) begin
						k_q     <= kc;
						p_q     <= '0;
						found_q <= 1'b0;
					end
				end
				DEC_ENC: begin
					pend_q <= 1'b0;
				end
				DEC_DIST: begin
					pend_q <= (diff_q != '0);
				end
				DEC_CMP: begin
					if (dist_q < lead_dist_q) begin
						found_q <= 1'b1;
					end
				end
				DEC_NEXT: begin
					if (p_q != last_p) begin
						p_q <= p_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Trial datapath and best-so-far.
	always_ff @(posedge clk) begin
		case (st_q)
			DEC_IDLE: begin
				lead_dist_q <= DIST_MAX;
			end
			DEC_SETUP: begin
				trial_q <= trial_c;
				flips_q <= flips_c;
			end
			DEC_SYN: begin
				data_q <= trial_q[CODE_LEN-1:PAR_LEN];
				errs_q <= ERRS_NONE;
			end
			DEC_LOOK: begin
				data_q <= corr[CODE_LEN-1:PAR_LEN];
				errs_q <= syn_rd.errs;
			end
			DEC_ENC: begin
				diff_q <= ({data_q, {PAR_LEN{1'b0}}} | rem_res) ^ hard;
				dist_q <= '0;
			end
			DEC_DIST: begin
				if (pend_q) begin
					dist_q <= dist_q + DIST_W'(mag_data);
				end
				if (diff_q != '0) begin
					diff_q[lo] <= 1'b0;
				end
			end
			DEC_CMP: begin
				if (dist_q < lead_dist_q) begin
					lead_dist_q <= dist_q;
					lead_errs_q <= ERRCNT_W'(errs_q) + ERRCNT_W'(flips_q);
					best_data_q <= data_q;
				end
			end
			DEC_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_data_q <= found_q ? best_data_q : '0;
					out_errs_q <= found_q ? lead_errs_q : '0;
					out_fail_q <= !found_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign data_word     = out_data_q;
	assign error_count   = out_errs_q;
	assign decode_failed = out_fail_q;

endmodule

>>> tb/tb_bch_31_21_chase_soft_decoder.sv
module tb_bch_31_21_chase_soft_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import bchcs_pkg::*;

	localparam int STALL_LIMIT = 40000;
	localparam int HOLD_CYCLES = 6000;
	localparam int SETTLE_CYCLES = 60;
	// Indexes past the register list; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       restart;
	} sample_beat_t;

	typedef struct {
		data_t                data;
		logic [ERRCNT_W-1:0]  errors;
		logic                 failed;
	} decode_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] soft_sample = '0;
	logic block_restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	data_t data_word;
	logic [ERRCNT_W-1:0] error_count;
	logic decode_failed;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	poly_t cfg_data = '0;

	bch_31_21_chase_soft_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.soft_sample(soft_sample), .block_restart(block_restart),
		.out_valid(out_valid), .out_ready(out_ready),
		.data_word(data_word), .error_count(error_count), .decode_failed(decode_failed),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	sample_beat_t   pending_beats[$];
	decode_result_t expected_results[$];
	int fail_count = 0;
	int send_idle_pct = 20;
	int recv_idle_pct = 50;
	int hold_request = 0;

	// Shadow copy of the decoder state.
	logic [DEPTH_W-1:0]          shadow_depth = RST_CHASE_DEPTH;
	poly_t                       shadow_poly = RST_GEN_POLY;
	int                          syn_errs[TBL_DEPTH];
	logic [31:0]                 syn_loc[TBL_DEPTH];
	logic signed [SAMPLE_W-1:0]  block_samples[CODE_LEN];
	int                          block_fill = 0;

	// Remainder of v modulo the polynomial, reducing by its actual highest set bit.
	function automatic logic [31:0] poly_mod(input poly_t poly, input logic [31:0] v);
		int deg;
		deg = -1;
		for (int b = POLY_W - 1; b >= 0; b--) begin
			if (poly[b] && deg < 0) begin
				deg = b;
			end
		end
		if (deg < 0) begin
			return v;
		end
		for (int i = 31; i >= deg; i--) begin
			if (v[i]) begin
				v ^= 32'(poly) << (i - deg);
			end
		end
		return v;
	endfunction

	// Single-bit patterns first so that they win any collision with a pair.
	function automatic void build_syndromes();
		logic [31:0] pat;
		logic [31:0] r;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			syn_errs[i] = 0;
			syn_loc[i] = '0;
		end
		for (int a = 0; a < CODE_LEN; a++) begin
			pat = 32'd1 << a;
			r = poly_mod(shadow_poly, pat);
			if (r < TBL_DEPTH) begin
				syn_errs[r] = 1;
				syn_loc[r] = pat;
			end
		end
		for (int a = 0; a < CODE_LEN; a++) begin
			for (int b = a + 1; b < CODE_LEN; b++) begin
				pat = (32'd1 << a) | (32'd1 << b);
				r = poly_mod(shadow_poly, pat);
				if (r < TBL_DEPTH && syn_errs[r] == 0) begin
					syn_errs[r] = 2;
					syn_loc[r] = pat;
				end
			end
		end
	endfunction

	// Chase search over the least reliable positions of the gathered block.
	function automatic decode_result_t chase_decode();
		decode_result_t res;
		logic [31:0] hard, trial, s, fixed, sys, cw, diff;
		int mag[CODE_LEN];
		int soft_pos[DEF_MAX_DEPTH + 1];
		int k, filled, flips, errs, trial_dist, lead_dist, lead_errs;
		logic [31:0] data, best_data;
		hard = '0;
		filled = 0;
		k = (shadow_depth > DEF_MAX_DEPTH) ? DEF_MAX_DEPTH : int'(shadow_depth);
		for (int i = 0; i < CODE_LEN; i++) begin
			hard = (hard << 1) | (block_samples[i] < 0 ? 32'd1 : 32'd0);
			mag[i] = block_samples[i] < 0 ? -int'(block_samples[i]) : int'(block_samples[i]);
			if (mag[i] > 32767) begin
				mag[i] = 32767;
			end
		end
		for (int i = 0; i <= DEF_MAX_DEPTH; i++) begin
			soft_pos[i] = 0;
		end
		// Strictly-less insertion keeps the earlier position ahead on a tie.
		for (int i = 0; i < CODE_LEN; i++) begin
			for (int j = 0; j < k; j++) begin
				if (j >= filled || mag[i] < mag[soft_pos[j]]) begin
					for (int t = k - 1; t > j; t--) begin
						soft_pos[t] = soft_pos[t - 1];
					end
					soft_pos[j] = i;
					if (filled < k) begin
						filled++;
					end
					break;
				end
			end
		end
		lead_dist = 32'hFFFFF;
		lead_errs = -1;
		best_data = '0;
		for (int p = 0; p < (1 << k); p++) begin
			trial = hard;
			flips = 0;
			for (int j = 0; j < k; j++) begin
				if ((p >> j) & 1) begin
					trial ^= 32'd1 << (30 - soft_pos[j]);
					flips++;
				end
			end
			s = poly_mod(shadow_poly, trial);
			errs = -1;
			if (s == 0) begin
				data = trial >> PAR_LEN;
				errs = 0;
			end else if (s < TBL_DEPTH && syn_errs[s] != 0) begin
				fixed = trial ^ syn_loc[s];
				data = (fixed >> PAR_LEN) & 32'h1FFFFF;
				errs = syn_errs[s];
			end
			if (errs >= 0) begin
				sys = data << PAR_LEN;
				cw = sys | poly_mod(shadow_poly, sys);
				diff = cw ^ hard;
				trial_dist = 0;
				for (int i = 0; i < CODE_LEN; i++) begin
					if (diff[30 - i]) begin
						trial_dist += mag[i];
					end
				end
				if (trial_dist < lead_dist) begin
					lead_dist = trial_dist;
					lead_errs = errs + flips;
					best_data = data;
				end
			end
		end
		if (lead_errs < 0) begin
			res.data = '0;
			res.errors = '0;
			res.failed = 1'b1;
		end else begin
			res.data = best_data[DATA_LEN-1:0];
			res.errors = lead_errs[ERRCNT_W-1:0];
			res.failed = 1'b0;
		end
		return res;
	endfunction

	// Gathers one accepted sample and predicts a result when a block completes.
	function automatic void gather_sample(input logic signed [SAMPLE_W-1:0] s, input logic r);
		if (r || block_fill >= CODE_LEN) begin
			block_fill = 0;
		end
		block_samples[block_fill] = s;
		block_fill++;
		if (block_fill == CODE_LEN) begin
			block_fill = 0;
			expected_results.push_back(chase_decode());
		end
	endfunction

	function automatic void queue_beat(input logic signed [SAMPLE_W-1:0] s, input logic r);
		sample_beat_t b;
		b.sample = s;
		b.restart = r;
		pending_beats.push_back(b);
	endfunction

	// A codeword of random data sent as soft values, with a few unreliable or wrong samples.
	function automatic void queue_codeword(input int max_errs, input int count);
		logic [31:0] sys, cw;
		int amp, nerr;
		logic bit_one;
		logic signed [SAMPLE_W-1:0] v;
		bit bad[CODE_LEN];
		sys = 32'($urandom_range(21'h1FFFFF)) << PAR_LEN;
		cw = sys | poly_mod(shadow_poly, sys);
		for (int i = 0; i < CODE_LEN; i++) begin
			bad[i] = 0;
		end
		nerr = $urandom_range(max_errs);
		for (int e = 0; e < nerr; e++) begin
			bad[$urandom_range(CODE_LEN - 1)] = 1;
		end
		for (int i = 0; i < count; i++) begin
			bit_one = cw[30 - i] ^ bad[i];
			case ($urandom_range(9))
				0: amp = $urandom_range(32767);
				1: amp = $urandom_range(15);
				default: amp = bad[i] ? $urandom_range(4000) : $urandom_range(32767, 2000);
			endcase
			v = bit_one ? -16'(amp) : 16'(amp);
			if (bit_one && $urandom_range(15) == 0) begin
				v = 16'sh8000;
			end
			queue_beat(v, i == 0 ? ($urandom_range(7) != 0) : 1'b0);
		end
	endfunction

	// Mostly well-formed blocks; now and then a truncated block or plain noise.
	function automatic void queue_random_blocks(input int blocks);
		for (int n = 0; n < blocks; n++) begin
			case ($urandom_range(9))
				0: queue_codeword(4, $urandom_range(30, 1));
				1: begin
					for (int i = 0; i < CODE_LEN; i++) begin
						queue_beat(16'($urandom_range(16'hFFFF)), i == 0);
					end
				end
				default: queue_codeword(6, CODE_LEN);
			endcase
		end
		// A restart on the closing block makes sure no truncated block swallows it.
		queue_codeword(3, CODE_LEN);
		pending_beats[pending_beats.size() - CODE_LEN].restart = 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input poly_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_CHASE_DEPTH) begin
			shadow_depth = val[DEPTH_W-1:0];
		end else if (idx == REG_GEN_POLY) begin
			shadow_poly = val;
			build_syndromes();
		end
		cfg_valid <= 1'b0;
	endtask

	// Sender pauses until every outstanding result is back and the block is quiet.
	task automatic drain();
		do @(posedge clk);
		while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sample driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				gather_sample(soft_sample, block_restart);
			end
			if (!in_valid || in_ready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					soft_sample <= pending_beats[0].sample;
					block_restart <= pending_beats[0].restart;
					in_valid <= 1'b1;
					void'(pending_beats.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random stalls and one long hold-off.
	int hold_left = 0;
	int hold_served = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected beat", data_word, 0);
				end else begin
					if (data_word !== expected_results[0].data)
						report_mismatch("data_word", data_word, expected_results[0].data);
					if (error_count !== expected_results[0].errors)
						report_mismatch("error_count", error_count, expected_results[0].errors);
					if (decode_failed !== expected_results[0].failed)
						report_mismatch("decode_failed", decode_failed,
							expected_results[0].failed);
					void'(expected_results.pop_front());
				end
			end
			if (hold_request > hold_served) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles with no beat on any channel.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		build_syndromes();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, equal reliabilities and a dropped partial block.
		for (int i = 0; i < CODE_LEN; i++)
			queue_beat(i % 2 ? 16'sh8000 : 16'sh7FFF, i == 0);
		for (int i = 0; i < 7; i++)
			queue_beat(-16'sd5, i == 0);
		for (int i = 0; i < CODE_LEN; i++)
			queue_beat(i % 5 == 0 ? -16'sd100 : 16'sd100, i == 0);
		for (int i = 0; i < CODE_LEN; i++)
			queue_beat(16'sd0, i == 0);
		drain();

		// Maximum depth through the out-of-range code, and ignored spare indexes.
		write_register(REG_CHASE_DEPTH, 11'd7);
		write_register(REG_SPARE_2, 11'd1234);
		write_register(REG_SPARE_3, 11'h7FF);
		hold_request = 1;
		queue_random_blocks(5);
		drain();

		send_idle_pct = 50;
		recv_idle_pct = 20;
		write_register(REG_CHASE_DEPTH, 11'd0);
		write_register(REG_GEN_POLY, 11'd1024);
		queue_random_blocks(3);
		drain();
		write_register(REG_GEN_POLY, 11'd2047);
		write_register(REG_CHASE_DEPTH, 11'd6);
		queue_random_blocks(3);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(REG_GEN_POLY, RST_GEN_POLY);
		for (int ph = 0; ph < 3; ph++) begin
			write_register(REG_CHASE_DEPTH, 11'($urandom_range(5, 1)));
			queue_random_blocks(2);
			drain();
		end
		write_register(REG_GEN_POLY, 11'($urandom_range(2047, 1024)));
		queue_random_blocks(2);
		drain();

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
